[design/spsl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsl_pkg : shared types and constants of the servo PD slew limiter
// Configuration layout, register indexes, reset values and the lane result
// record passed from the lanes to the merge stage.
// ----------------------------------------------------------------------------
package spsl_pkg;

    // Number of servo lanes carried on the stream ports
    localparam int IO_LANES  = 4;
    localparam int GAIN_FRAC = 12;
    localparam int CFG_W     = 16;
    localparam int IDX_W     = 2;

    // Register indexes of the configuration port
    localparam logic [IDX_W-1:0] CFG_PROP_GAIN  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_DERIV_GAIN = 2'd1;
    localparam logic [IDX_W-1:0] CFG_MAX_STEP   = 2'd2;

    // Reset values: gains of about 0.6 and 0.05, step of about 0.8 degree
    localparam logic [CFG_W-1:0] RST_PROP_GAIN  = 16'd2458;
    localparam logic [CFG_W-1:0] RST_DERIV_GAIN = 16'd205;
    localparam logic [CFG_W-1:0] RST_MAX_STEP   = 16'd205;

    typedef struct packed {
        logic [CFG_W-1:0] prop_gain;
        logic [CFG_W-1:0] deriv_gain;
        logic [CFG_W-1:0] max_step;
    } t_cfg;

    // What one lane reports for the current tick
    typedef struct packed {
        logic [7:0] angle;
        logic       near;
    } t_lane_res;

endpackage

[design/spsl_lane.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsl_lane : one servo lane of the PD slew limiter
// Holds the fixed-point angle and last error of one servo, forms the PD step,
// limits it, applies it and clamps the angle to the full-scale range.
// ----------------------------------------------------------------------------
module spsl_lane import spsl_pkg::*; #(
    parameter int FRAC_BITS = 8
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cfg       i_cfg,
    input  logic [7:0] i_target,
    output t_lane_res  o_res
);

    localparam int AW = 8 + FRAC_BITS;           // angle, unsigned
    localparam int EW = 9 + FRAC_BITS;           // error, signed
    localparam int DW = EW + 1;                  // error change, signed
    localparam int PW = CFG_W + 1 + EW;          // proportional product
    localparam int QW = CFG_W + 1 + DW;          // derivative product
    localparam int SW = QW + 1;                  // summed step
    localparam int MW = CFG_W + 1;               // limited step
    localparam int LW = ((AW + 1 > MW) ? AW + 1 : MW) + 1;

    localparam logic [AW-1:0] FULL_SCALE = AW'(180 << FRAC_BITS);
    localparam logic [AW-1:0] MID_SCALE  = AW'(90 << FRAC_BITS);
    localparam logic signed [EW-1:0] ONE_DEG = EW'(1 << FRAC_BITS);

    logic [AW-1:0]        r_angle;
    logic signed [EW-1:0] r_prev_err;
    logic [AW-1:0]        n_angle;

    logic signed [EW-1:0] err;
    logic signed [DW-1:0] der;
    logic signed [PW-1:0] prod_p;
    logic signed [QW-1:0] prod_d;
    logic signed [PW-1:0] shr_p;
    logic signed [QW-1:0] shr_d;
    logic signed [SW-1:0] step;
    logic signed [SW-1:0] lim_pos;
    logic signed [SW-1:0] lim_neg;
    logic signed [MW-1:0] step_lim;
    logic signed [LW-1:0] sum;
    logic signed [LW-1:0] full_w;

    // Error against the target and its change since the last tick
    assign err = $signed({1'b0, i_target, {FRAC_BITS{1'b0}}}) - $signed({1'b0, r_angle});
    assign der = $signed({err[EW-1], err}) - $signed({r_prev_err[EW-1], r_prev_err});

    // PD products, floored by arithmetic shift
    assign prod_p = $signed({1'b0, i_cfg.prop_gain}) * err;
    assign prod_d = $signed({1'b0, i_cfg.deriv_gain}) * der;
    assign shr_p  = prod_p >>> GAIN_FRAC;
    assign shr_d  = prod_d >>> GAIN_FRAC;
    assign step   = $signed({{(SW-PW){shr_p[PW-1]}}, shr_p})
                  + $signed({{(SW-QW){shr_d[QW-1]}}, shr_d});

    // Limit the step to plus or minus the rate limit
    assign lim_pos = $signed({{(SW-CFG_W){1'b0}}, i_cfg.max_step});
    assign lim_neg = -lim_pos;

    always_comb begin
        if (step > lim_pos) begin
            step_lim = lim_pos[MW-1:0];
        end else if (step < lim_neg) begin
            step_lim = lim_neg[MW-1:0];
        end else begin
            step_lim = step[MW-1:0];
        end
    end

    // Apply the step and clamp to 0..full scale
    assign sum    = $signed({{(LW-AW){1'b0}}, r_angle})
                  + $signed({{(LW-MW){step_lim[MW-1]}}, step_lim});
    assign full_w = $signed({{(LW-AW){1'b0}}, FULL_SCALE});

    always_comb begin
        if (sum < 0) begin
            n_angle = '0;
        end else if (sum > full_w) begin
            n_angle = FULL_SCALE;
        end else begin
            n_angle = sum[AW-1:0];
        end
    end

    // Hold the lane state; advance it on each accepted item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle    <= MID_SCALE;
            r_prev_err <= '0;
        end else if (i_en) begin
            r_angle    <= n_angle;
            r_prev_err <= err;
        end
    end

    assign o_res.angle = n_angle[AW-1:FRAC_BITS];
    assign o_res.near  = (err <= ONE_DEG) && (err >= -ONE_DEG);

endmodule

[design/spsl_merge.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spsl_merge : lane merge and output stage
// Combines the lane results into one item (angles and arrived flag) and
// holds it in an output register backed by a skid register.
// ----------------------------------------------------------------------------
module spsl_merge import spsl_pkg::*; #(
    parameter int NUM_SERVOS = 4
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  t_lane_res             i_res [NUM_SERVOS],
    output logic                  o_ready,
    output logic                  o_valid,
    input  logic                  i_pop_ready,
    output logic [8*IO_LANES-1:0] o_data,
    output logic                  o_flag
);

    logic [8*IO_LANES-1:0] n_data;
    logic                  n_flag;

    logic [8*IO_LANES-1:0] r_out_data;
    logic                  r_out_flag;
    logic                  r_out_valid;
    logic [8*IO_LANES-1:0] r_skid_data;
    logic                  r_skid_flag;
    logic                  r_skid_valid;
    logic                  pop;

    // Pack the visible lanes; arrived only when every lane is near its target
    always_comb begin
        n_data = '0;
        n_flag = 1'b1;
        for (int i = 0; i < NUM_SERVOS; i++) begin
            n_flag = n_flag & i_res[i].near;
        end
        for (int i = 0; i < IO_LANES; i++) begin
            if (i < NUM_SERVOS) begin
                n_data[8*i +: 8] = i_res[i].angle;
            end
        end
    end

    assign pop = r_out_valid && i_pop_ready;

    // Output register with a skid stage behind it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_push && (!r_out_valid || pop)) begin
                r_out_valid <= 1'b1;
            end else if (i_push) begin
                r_skid_valid <= 1'b1;
            end else if (pop && r_skid_valid) begin
                r_skid_valid <= 1'b0;
            end else if (pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && (!r_out_valid || pop)) begin
            r_out_data <= n_data;
            r_out_flag <= n_flag;
        end else if (i_push) begin
            r_skid_data <= n_data;
            r_skid_flag <= n_flag;
        end else if (pop && r_skid_valid) begin
            r_out_data <= r_skid_data;
            r_out_flag <= r_skid_flag;
        end
    end

    assign o_ready = !r_skid_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out_data;
    assign o_flag  = r_out_flag;

endmodule

[design/servo_pd_slew_limiter_top.sv]
`timescale 1ns / 1ps
// A tick's result is registered in the output, or the skid while output is stalled.
// Throughput: one item per cycle while the skid register is empty; every lane
// does PD step and clamp in the accept cycle; tick-to-tick feedback sets the rate.
// A two-deep output (register plus skid) keeps input taken while a result waits.
// Reset (synchronous, active low): gains and rate limit to their defaults,
// angles to 90 degrees, last errors to zero, output empty.
// ----------------------------------------------------------------------------
// servo_pd_slew_limiter_top : four-servo PD controller with slew limit
// Configuration registers, parallel servo lanes and the merge/output stage.
// ----------------------------------------------------------------------------
module servo_pd_slew_limiter_top import spsl_pkg::*; #(
    parameter int NUM_SERVOS = 4,
    parameter int FRAC_BITS  = 8
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_we,
    input  logic [IDX_W-1:0]      i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data,
    // input stream
    input  logic                  i_s_tvalid,
    output logic                  o_s_tready,
    input  logic [8*IO_LANES-1:0] i_s_tdata,   // target_0, target_1, target_2, target_3
    // output stream
    output logic                  o_m_tvalid,
    input  logic                  i_m_tready,
    output logic [8*IO_LANES-1:0] o_m_tdata,   // angle_0, angle_1, angle_2, angle_3
    output logic                  o_m_tuser    // arrived
);

    t_cfg      r_cfg;
    t_lane_res lane_res [NUM_SERVOS];
    logic      accept;

    // Configuration registers; writes beyond the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.prop_gain  <= RST_PROP_GAIN;
            r_cfg.deriv_gain <= RST_DERIV_GAIN;
            r_cfg.max_step   <= RST_MAX_STEP;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_PROP_GAIN:  r_cfg.prop_gain  <= i_cfg_data;
                CFG_DERIV_GAIN: r_cfg.deriv_gain <= i_cfg_data;
                CFG_MAX_STEP:   r_cfg.max_step   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign accept = i_s_tvalid && o_s_tready;

    // Servo lanes; lanes past the stream width see a target of zero
    for (genvar g = 0; g < NUM_SERVOS; g++) begin : g_lane
        logic [7:0] target;
        if (g < IO_LANES) begin : g_io
            assign target = i_s_tdata[8*g +: 8];
        end else begin : g_zero
            assign target = 8'd0;
        end

        spsl_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (accept),
            .i_cfg    (r_cfg),
            .i_target (target),
            .o_res    (lane_res[g])
        );
    end

    spsl_merge #(
        .NUM_SERVOS (NUM_SERVOS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (accept),
        .i_res       (lane_res),
        .o_ready     (o_s_tready),
        .o_valid     (o_m_tvalid),
        .i_pop_ready (i_m_tready),
        .o_data      (o_m_tdata),
        .o_flag      (o_m_tuser)
    );

endmodule
